// File: design/rtri_pkg.sv
// Package for the RSSI trilateration block: field widths, register codes,
// and the elaboration-time builder for the RSSI-to-distance table. No dependencies.
`default_nettype none

package rtri_pkg;

	localparam int DIST_FRAC_BITS_DEF = 8;
	localparam int RSSI_W   = 8;
	localparam int ANCHOR_W = 16;
	localparam int DIST_W   = 19;
	localparam int POS_W    = 32;
	localparam int COEF_W   = ANCHOR_W + 2;                  // 2*(b - a)
	localparam int SQ_W     = 2 * ANCHOR_W;                  // coordinate squared
	localparam int K_W      = SQ_W + 1;                      // sum of four squares
	localparam int DEN_W    = 2 * COEF_W;                    // e*a - b*d
	localparam int CT_W     = 2 * DIST_W + 2;                // constant terms C, F
	localparam int PROD_W   = CT_W + COEF_W;
	localparam int NUM_W    = PROD_W + 1;
	localparam int QB       = POS_W - 1;                     // quotient magnitude bits
	localparam int DIV_LAT  = QB + 3;
	localparam int ROM_DEPTH = 1 << RSSI_W;

	typedef enum logic [2:0] {
		REG_ANCHOR_A_X = 3'd0,
		REG_ANCHOR_A_Y = 3'd1,
		REG_ANCHOR_B_X = 3'd2,
		REG_ANCHOR_B_Y = 3'd3,
		REG_ANCHOR_C_X = 3'd4,
		REG_ANCHOR_C_Y = 3'd5
	} reg_idx_t;

	// 10^(m/20) scaled by 1e8, m = 0..19
	localparam longint unsigned POW_TAB [20] = '{
		64'd100000000, 64'd112201845, 64'd125892541, 64'd141253754, 64'd158489319,
		64'd177827941, 64'd199526231, 64'd223872114, 64'd251188643, 64'd281838293,
		64'd316227766, 64'd354813389, 64'd398107171, 64'd446683592, 64'd501187234,
		64'd562341325, 64'd630957344, 64'd707945784, 64'd794328235, 64'd891250938
	};

	typedef logic [63:0] rom_arr_t [ROM_DEPTH];

	// shift-subtract quotient, used only while building the table
	function automatic longint unsigned udiv_u64(input longint unsigned n,
			input longint unsigned d);
		longint unsigned quo_v;
		longint unsigned rem_v;
		quo_v = 0;
		rem_v = 0;
		for (int b = 63; b >= 0; b--) begin
			rem_v = {rem_v[62:0], n[b]};
			if (rem_v >= d) begin
				rem_v = rem_v - d;
				quo_v[b] = 1'b1;
			end
		end
		return quo_v;
	endfunction

	// distance = 100 * 10^((-54 - rssi)/20) with frac fraction bits, rounded half up
	function automatic rom_arr_t build_rom(input int frac);
		rom_arr_t res;
		int rssi;
		int e;
		int q;
		int m;
		longint unsigned num;
		longint unsigned dv;
		for (int code = 0; code < ROM_DEPTH; code++) begin
			rssi = (code < ROM_DEPTH / 2) ? code : code - ROM_DEPTH;
			e = -54 - rssi;
			// floor split e = 20*q + m
			q = 0;
			m = e;
			while (m < 0) begin
				m = m + 20;
				q = q - 1;
			end
			while (m >= 20) begin
				m = m - 20;
				q = q + 1;
			end
			num = (64'd100 << frac) * POW_TAB[m];
			dv = 64'd100000000;
			for (int i = 0; i < q; i++) num = num * 64'd10;
			for (int i = 0; i > q; i--) dv = dv * 64'd10;
			res[code] = udiv_u64(num + (dv >> 1), dv);
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// File: design/rtri_dist_lane.sv
// One distance lane: table lookup of an RSSI reading, then the squared distance.
// Depends on rtri_pkg.
`default_nettype none

module rtri_dist_lane import rtri_pkg::*; #(
	parameter int FB = DIST_FRAC_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic [RSSI_W-1:0]          rssi,
	output logic      [2*(DIST_W+FB)-1:0]   r_sq,
	output logic      [DIST_W-1:0]          dist_trunc
);

	localparam int RW = DIST_W + FB;
	localparam rom_arr_t ROM = build_rom(FB);

	logic [RW-1:0]   r_s1;
	logic [2*RW-1:0] sq_s2;
	logic [DIST_W-1:0] dist_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1    <= ROM[rssi][RW-1:0];
			sq_s2   <= (2*RW)'(r_s1) * (2*RW)'(r_s1);
			dist_s2 <= r_s1[RW-1:FB];
		end
	end

	assign r_sq       = sq_s2;
	assign dist_trunc = dist_s2;

endmodule

`default_nettype wire

// File: design/rtri_div.sv
// Pipelined signed divider, truncating toward zero, quotient saturated to 32 bits.
// One quotient bit per stage. Depends on rtri_pkg.
`default_nettype none

module rtri_div import rtri_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic signed [NUM_W-1:0] num,
	input  wire logic signed [DEN_W-1:0] den,
	output logic signed [POS_W-1:0]      quo
);

	logic [NUM_W-1:0] nmag_s1;
	logic [DEN_W-1:0] dmag_s1;
	logic             neg_s1;

	logic [DEN_W-1:0] rem_q  [0:QB];
	logic [QB-1:0]    quo_q  [0:QB];
	logic [QB-1:0]    nlo_q  [0:QB];
	logic [DEN_W-1:0] dmag_q [0:QB];
	logic             neg_q  [0:QB];
	logic             ovf_q  [0:QB];
	logic signed [POS_W-1:0] quo_o;

	logic ovf_c;
	assign ovf_c = DEN_W'(nmag_s1[NUM_W-1:QB]) >= dmag_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			nmag_s1 <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			dmag_s1 <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
			neg_s1  <= num[NUM_W-1] ^ den[DEN_W-1];

			// quotient magnitude >= 2^31 saturates; otherwise the high part is the start remainder
			rem_q[0]  <= ovf_c ? '0 : DEN_W'(nmag_s1[NUM_W-1:QB]);
			quo_q[0]  <= '0;
			nlo_q[0]  <= nmag_s1[QB-1:0];
			dmag_q[0] <= dmag_s1;
			neg_q[0]  <= neg_s1;
			ovf_q[0]  <= ovf_c;
		end
	end

	for (genvar i = 0; i < QB; i++) begin : g_step
		logic [DEN_W:0] trial;
		logic           ge;
		assign trial = {rem_q[i], nlo_q[i][QB-1]};
		assign ge    = trial >= {1'b0, dmag_q[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i+1]  <= ge ? DEN_W'(trial - {1'b0, dmag_q[i]}) : DEN_W'(trial);
				quo_q[i+1]  <= {quo_q[i][QB-2:0], ge};
				nlo_q[i+1]  <= {nlo_q[i][QB-2:0], 1'b0};
				dmag_q[i+1] <= dmag_q[i];
				neg_q[i+1]  <= neg_q[i];
				ovf_q[i+1]  <= ovf_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (ovf_q[QB]) begin
				quo_o <= neg_q[QB] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
			end else if (neg_q[QB]) begin
				quo_o <= -POS_W'(quo_q[QB]);
			end else begin
				quo_o <= POS_W'(quo_q[QB]);
			end
		end
	end

	assign quo = quo_o;

endmodule

`default_nettype wire

// File: design/rssi_trilateration_2d.sv
// RSSI trilateration top level: anchor registers, three distance lanes, circle
// difference solver and two divider lanes. Depends on rtri_pkg, rtri_dist_lane, rtri_div.
//
// Usage:
//  - s_* channel: one transaction carries rssi_a, rssi_b, rssi_c (signed dBm).
//  - m_* channel: one transaction per input with dist_a/b/c, pos_x, pos_y and
//    the degenerate flag in m_tuser (collinear anchors, position reads 0).
//  - wr_en/wr_addr/wr_data write the six anchor coordinates; write them only
//    while no transaction is in flight. Unknown addresses are ignored.
//  - Data passes through table lookup and squaring, then the
//    linear-system terms, then the divider lanes (one quotient bit per stage).
//  - Throughput is one transaction per cycle; the whole pipeline advances
//    together, so when m_tready is low with a result waiting, s_tready drops
//    and every stage holds.
//  - Reset clears anchors to 0 and empties the pipeline.
`default_nettype none

module rssi_trilateration_2d import rtri_pkg::*; #(
	parameter int DIST_FRAC_BITS = DIST_FRAC_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [23:0]         s_tdata,   // rssi_a[7:0], rssi_b[15:8], rssi_c[23:16]
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [127:0]             m_tdata,   // dist_a, dist_b, dist_c, pos_x, pos_y, zero fill
	output logic [0:0]               m_tuser,   // degenerate
	input  wire logic                wr_en,
	input  wire logic [2:0]          wr_addr,
	input  wire logic [ANCHOR_W-1:0] wr_data
);

	localparam int FB   = DIST_FRAC_BITS;
	localparam int RW   = DIST_W + FB;
	localparam int SQW  = 2 * RW;
	localparam int VW   = SQW + 2;
	localparam int SH   = 2 * FB;
	localparam int LAT  = 6 + DIV_LAT;
	localparam int DDLY = LAT - 2;
	localparam int GDLY = DIV_LAT;
	localparam logic [VW-1:0] BIAS = (VW'(1) << SH) - VW'(1);

	// anchor registers
	logic signed [ANCHOR_W-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q <= '0; ay_q <= '0; bx_q <= '0;
			by_q <= '0; cx_q <= '0; cy_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_addr))
				REG_ANCHOR_A_X: ax_q <= wr_data;
				REG_ANCHOR_A_Y: ay_q <= wr_data;
				REG_ANCHOR_B_X: bx_q <= wr_data;
				REG_ANCHOR_B_Y: by_q <= wr_data;
				REG_ANCHOR_C_X: cx_q <= wr_data;
				REG_ANCHOR_C_Y: cy_q <= wr_data;
				default: ;
			endcase
		end
	end

	// terms that follow from the anchors alone, refreshed every cycle
	logic signed [COEF_W-1:0] ca_q, cb_q, cd_q, ce_q;
	logic signed [SQ_W-1:0]   sax_q, say_q, sbx_q, sby_q, scx_q, scy_q;
	logic signed [K_W-1:0]    k1_q, k2_q;
	logic signed [DEN_W-1:0]  pd1_q, pd2_q, den_q;

	always_ff @(posedge clk) begin
		ca_q  <= {COEF_W'(bx_q - ax_q) <<< 1};
		cb_q  <= {COEF_W'(by_q - ay_q) <<< 1};
		cd_q  <= {COEF_W'(cx_q - bx_q) <<< 1};
		ce_q  <= {COEF_W'(cy_q - by_q) <<< 1};
		sax_q <= SQ_W'(ax_q) * SQ_W'(ax_q);
		say_q <= SQ_W'(ay_q) * SQ_W'(ay_q);
		sbx_q <= SQ_W'(bx_q) * SQ_W'(bx_q);
		sby_q <= SQ_W'(by_q) * SQ_W'(by_q);
		scx_q <= SQ_W'(cx_q) * SQ_W'(cx_q);
		scy_q <= SQ_W'(cy_q) * SQ_W'(cy_q);
		k1_q  <= K_W'(sbx_q) + K_W'(sby_q) - K_W'(sax_q) - K_W'(say_q);
		k2_q  <= K_W'(scx_q) + K_W'(scy_q) - K_W'(sbx_q) - K_W'(sby_q);
		pd1_q <= DEN_W'(ce_q) * DEN_W'(ca_q);
		pd2_q <= DEN_W'(cb_q) * DEN_W'(cd_q);
		den_q <= pd1_q - pd2_q;
	end

	// pipeline control
	logic           en;
	logic [LAT-1:0] vld_q;

	assign s_tready = !m_tvalid || m_tready;
	assign en       = s_tready;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// distance lanes
	logic [SQW-1:0]    sqa, sqb, sqc;
	logic [DIST_W-1:0] da, db, dc;

	rtri_dist_lane #(.FB(FB)) u_lane_a (
		.clk(clk), .en(en), .rssi(s_tdata[7:0]), .r_sq(sqa), .dist_trunc(da)
	);
	rtri_dist_lane #(.FB(FB)) u_lane_b (
		.clk(clk), .en(en), .rssi(s_tdata[15:8]), .r_sq(sqb), .dist_trunc(db)
	);
	rtri_dist_lane #(.FB(FB)) u_lane_c (
		.clk(clk), .en(en), .rssi(s_tdata[23:16]), .r_sq(sqc), .dist_trunc(dc)
	);

	// constant terms: exact sum, then shift with truncation toward zero
	logic signed [VW-1:0]     k1_ext, k2_ext, v1_s3, v2_s3, t1, t2;
	logic signed [CT_W-1:0]   cc_s4, cf_s4;
	logic signed [PROD_W-1:0] p1_s5, p2_s5, p3_s5, p4_s5;
	logic signed [NUM_W-1:0]  nx_s6, ny_s6;
	logic signed [DEN_W-1:0]  den_s6;
	logic                     deg_s6;

	assign k1_ext = VW'(k1_q) <<< SH;
	assign k2_ext = VW'(k2_q) <<< SH;
	assign t1 = v1_s3 + (v1_s3[VW-1] ? signed'(BIAS) : signed'(VW'(0)));
	assign t2 = v2_s3 + (v2_s3[VW-1] ? signed'(BIAS) : signed'(VW'(0)));

	always_ff @(posedge clk) begin
		if (en) begin
			v1_s3  <= signed'(VW'(sqa)) - signed'(VW'(sqb)) + k1_ext;
			v2_s3  <= signed'(VW'(sqb)) - signed'(VW'(sqc)) + k2_ext;
			cc_s4  <= CT_W'(t1 >>> SH);
			cf_s4  <= CT_W'(t2 >>> SH);
			p1_s5  <= PROD_W'(cc_s4) * PROD_W'(ce_q);
			p2_s5  <= PROD_W'(cf_s4) * PROD_W'(cb_q);
			p3_s5  <= PROD_W'(cc_s4) * PROD_W'(cd_q);
			p4_s5  <= PROD_W'(ca_q) * PROD_W'(cf_s4);
			nx_s6  <= NUM_W'(p1_s5) - NUM_W'(p2_s5);
			// y = (cc*cd - ca*cf) / -den, taken as (ca*cf - cc*cd) / den
			ny_s6  <= NUM_W'(p4_s5) - NUM_W'(p3_s5);
			den_s6 <= den_q;
			deg_s6 <= (den_q == '0);
		end
	end

	logic signed [POS_W-1:0] qx, qy;

	rtri_div u_div_x (.clk(clk), .en(en), .num(nx_s6), .den(den_s6), .quo(qx));
	rtri_div u_div_y (.clk(clk), .en(en), .num(ny_s6), .den(den_s6), .quo(qy));

	// alignment of distances and flag with the divider outputs
	logic [3*DIST_W-1:0] dist_q [DDLY];
	logic                deg_q  [GDLY];

	always_ff @(posedge clk) begin
		if (en) begin
			dist_q[0] <= {dc, db, da};
			for (int i = 1; i < DDLY; i++) dist_q[i] <= dist_q[i-1];
			deg_q[0] <= deg_s6;
			for (int i = 1; i < GDLY; i++) deg_q[i] <= deg_q[i-1];
		end
	end

	// merge: collinear anchors force the position to zero
	logic                    deg_o;
	logic signed [POS_W-1:0] px, py;

	assign deg_o = deg_q[GDLY-1];
	assign px    = deg_o ? '0 : qx;
	assign py    = deg_o ? '0 : qy;

	assign m_tdata = {7'd0, py, px, dist_q[DDLY-1]};
	assign m_tuser = deg_o;

	ap_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[120:57] == '0)
		else $error("degenerate result with nonzero position");

	ap_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");

	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(vld_q))
		else $error("pipeline moved while output stalled");

endmodule

`default_nettype wire
